/* rtl/psg_pkg.sv */
// Shared types, constants and the attenuation level table of the sound generator.
`default_nettype none

package psg_pkg;

   // voice numbering and widths
   localparam int unsigned VOICES     = 4;
   localparam int unsigned TONES      = 3;
   localparam int unsigned CNT_W      = 13;
   localparam int unsigned LIMIT_W    = CNT_W + 1;
   localparam int unsigned LFSR_W     = 15;
   localparam int unsigned LEVEL_W    = 14;
   localparam int unsigned SAMPLE_W   = 17;

   // voice memory entry: polarity bit over the phase count
   localparam int unsigned ENTRY_W    = CNT_W + 1;

   typedef logic [1:0] voice_type;

   localparam voice_type NOISE_VOICE = 2'd3;
   localparam voice_type LAST_VOICE  = 2'd3;
   localparam voice_type FIRST_VOICE = 2'd0;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   // attenuation code that mutes a voice
   localparam logic [3:0] ATT_MUTE = 4'hF;

   // noise rate code that borrows the third tone period
   localparam logic [1:0] RATE_TONE = 2'd3;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h4000;

   // per-step control from the sequencer to the voice unit
   typedef struct packed {
      logic                rd_en;
      voice_type           rd_addr;
      logic                run;
      voice_type           voice;
      logic                active;
      logic                white;
      logic [LIMIT_W-1:0]  limit;
   } voice_ctrl_type;

   // 2 dB steps, round(8192 * 10^(-v/10)), code 15 silent
   function automatic logic [LEVEL_W-1:0] level_of(input logic [3:0] att);
      logic [LEVEL_W-1:0] lvl;
      unique case (att)
         4'd0:    lvl = 14'd8192;
         4'd1:    lvl = 14'd6507;
         4'd2:    lvl = 14'd5169;
         4'd3:    lvl = 14'd4106;
         4'd4:    lvl = 14'd3261;
         4'd5:    lvl = 14'd2591;
         4'd6:    lvl = 14'd2058;
         4'd7:    lvl = 14'd1635;
         4'd8:    lvl = 14'd1298;
         4'd9:    lvl = 14'd1031;
         4'd10:   lvl = 14'd819;
         4'd11:   lvl = 14'd651;
         4'd12:   lvl = 14'd517;
         4'd13:   lvl = 14'd411;
         4'd14:   lvl = 14'd326;
         default: lvl = 14'd0;
      endcase
      return lvl;
   endfunction

endpackage

`default_nettype wire

/* rtl/psg_voice_unit.sv */
// Voice state memory (phase count and square polarity) with the count/toggle logic and noise LFSR.
`default_nettype none

module psg_voice_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire psg_pkg::voice_ctrl_type ctrl,
   output logic                        positive
);

   // {polarity, count} per voice; the noise entry's polarity bit is unused
   logic [psg_pkg::ENTRY_W-1:0] mem [psg_pkg::VOICES];
   logic [psg_pkg::VOICES-1:0] vld_ff, vld_in;
   logic [psg_pkg::ENTRY_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [psg_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;

   logic [psg_pkg::ENTRY_W-1:0] entry;
   logic [psg_pkg::CNT_W-1:0]   count;
   logic                        pol;
   logic [psg_pkg::LIMIT_W-1:0] next_cnt;
   logic                        hit;
   logic [psg_pkg::CNT_W-1:0]   new_cnt;
   logic                        new_pol;
   logic                        is_noise;
   logic                        fb;
   logic                        wr_en;

   // memory: one write and one read per cycle, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ctrl.voice] <= {new_pol, new_cnt};
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   // entries not yet written read as count zero, polarity positive
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         lfsr_ff   <= psg_pkg::LFSR_SEED;
      end else begin
         vld_ff  <= vld_in;
         lfsr_ff <= lfsr_in;
         if (ctrl.rd_en) begin
            rd_vld_ff <= vld_ff[ctrl.rd_addr];
         end
      end
   end

   // count advance and toggle/shift decision
   always_comb begin
      entry    = rd_vld_ff ? rd_data_ff : {1'b1, {psg_pkg::CNT_W{1'b0}}};
      count    = entry[psg_pkg::CNT_W-1:0];
      pol      = entry[psg_pkg::ENTRY_W-1];
      is_noise = (ctrl.voice == psg_pkg::NOISE_VOICE);
      next_cnt = {1'b0, count} + psg_pkg::LIMIT_W'(1);
      hit      = (next_cnt >= ctrl.limit);
      new_cnt  = hit ? '0 : next_cnt[psg_pkg::CNT_W-1:0];
      new_pol  = (hit && !is_noise) ? ~pol : pol;
      wr_en    = ctrl.run && ctrl.active;

      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[ctrl.voice] = 1'b1;
      end

      fb      = ctrl.white ? (lfsr_ff[0] ^ lfsr_ff[3]) : lfsr_ff[0];
      lfsr_in = lfsr_ff;
      if (wr_en && is_noise && hit) begin
         lfsr_in = {fb, lfsr_ff[psg_pkg::LFSR_W-1:1]};
      end

      positive = is_noise ? lfsr_in[0] : new_pol;
   end

endmodule

`default_nettype wire

/* rtl/psg_tone_noise_generator.sv */
// Top level of the four-voice tone and noise sound generator.
`default_nettype none

// Four-voice sound generator: three square-wave tones and one LFSR noise voice.
// A word with req_kind = 0 is a register write byte (latch byte when bit 7 is
// set, data byte otherwise), taken with no result. A word with req_kind = 1 is
// a sample tick: the voices are stepped one per cycle, the last one only while
// the output register can take the result, through a shared count/toggle unit
// whose state lives in a four-entry synchronous memory, and each tick gives one
// signed 17-bit rsp_sample (32768 = 1.0). A new word is taken in the cycle the
// previous tick finishes, so a new tick is not taken while the last one is still
// stepping; the result sits in an output register and only holds the block when
// it is still stalled as the next result is ready.

module psg_tone_noise_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [16:0] rsp_sample
);

   // programmable registers
   logic [9:0] tone_period_ff [psg_pkg::TONES];
   logic [3:0] att_ff [psg_pkg::VOICES];
   logic [2:0] noise_ctrl_ff;
   logic [1:0] latch_ch_ff;
   logic       latch_vol_ff;

   // sequencer and output
   logic                            busy_ff, busy_in;
   psg_pkg::voice_type              step_ff, step_in;
   logic signed [psg_pkg::SAMPLE_W-1:0] acc_ff, acc_in;
   logic signed [psg_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                        accept;
   logic                        accept_tick;
   logic                        accept_write;
   logic                        out_free;
   logic                        run;
   logic                        last;
   logic [3:0]                  cur_att;
   logic [9:0]                  cur_period;
   logic [psg_pkg::LEVEL_W-1:0] lvl;
   logic signed [psg_pkg::SAMPLE_W-1:0] contrib;
   logic                        positive;
   psg_pkg::voice_ctrl_type     ctrl;

   // handshake
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      last         = (step_ff == psg_pkg::LAST_VOICE);
      run          = busy_ff && (!last || out_free);
      req_stall    = busy_ff && !(last && out_free);
      accept       = req_valid && !req_stall;
      accept_tick  = accept && (req_kind == psg_pkg::KIND_TICK);
      accept_write = accept && (req_kind == psg_pkg::KIND_WRITE);
   end

   // parameters of the voice in this step
   always_comb begin
      cur_att    = att_ff[step_ff];
      cur_period = 10'd0;
      if (step_ff != psg_pkg::NOISE_VOICE) begin
         cur_period = tone_period_ff[step_ff];
      end

      ctrl.rd_en   = accept_tick || (run && !last);
      ctrl.rd_addr = accept_tick ? psg_pkg::FIRST_VOICE : step_ff + 2'd1;
      ctrl.run     = run;
      ctrl.voice   = step_ff;
      ctrl.white   = noise_ctrl_ff[2];
      if (step_ff == psg_pkg::NOISE_VOICE) begin
         ctrl.active = (cur_att != psg_pkg::ATT_MUTE);
         if (noise_ctrl_ff[1:0] == psg_pkg::RATE_TONE) begin
            ctrl.limit = {1'b0, tone_period_ff[2], 3'b000};
         end else begin
            ctrl.limit = psg_pkg::LIMIT_W'(128) << noise_ctrl_ff[1:0];
         end
      end else begin
         ctrl.active = (cur_att != psg_pkg::ATT_MUTE) && (cur_period != 10'd0);
         ctrl.limit  = {1'b0, cur_period, 3'b000};
      end
   end

   psg_voice_unit u_voice (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .positive (positive)
   );

   // mix: signed level of the stepped voice
   always_comb begin
      lvl     = psg_pkg::level_of(cur_att);
      contrib = '0;
      if (ctrl.active) begin
         contrib = positive ? $signed({3'b000, lvl}) : -$signed({3'b000, lvl});
      end
   end

   // sequencer next state
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (run) begin
         acc_in  = acc_ff + contrib;
         step_in = step_ff + 2'd1;
         if (last) begin
            sample_in    = acc_ff + contrib;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
         end
      end
      if (accept_tick) begin
         busy_in = 1'b1;
         step_in = psg_pkg::FIRST_VOICE;
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= psg_pkg::FIRST_VOICE;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff    <= acc_in;
      sample_ff <= sample_in;
   end

   // register write bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psg_pkg::TONES; i++) begin
            tone_period_ff[i] <= 10'd0;
         end
         for (int i = 0; i < psg_pkg::VOICES; i++) begin
            att_ff[i] <= psg_pkg::ATT_MUTE;
         end
         noise_ctrl_ff <= 3'd0;
         latch_ch_ff   <= 2'd0;
         latch_vol_ff  <= 1'b0;
      end else if (accept_write) begin
         if (req_data[7]) begin
            latch_ch_ff  <= req_data[6:5];
            latch_vol_ff <= req_data[4];
            if (req_data[4]) begin
               att_ff[req_data[6:5]] <= req_data[3:0];
            end else if (req_data[6:5] == psg_pkg::NOISE_VOICE) begin
               noise_ctrl_ff <= req_data[2:0];
            end else begin
               tone_period_ff[req_data[6:5]] <=
                  {tone_period_ff[req_data[6:5]][9:4], req_data[3:0]};
            end
         end else if (!latch_vol_ff && latch_ch_ff != psg_pkg::NOISE_VOICE) begin
            tone_period_ff[latch_ch_ff] <= {req_data[5:0], tone_period_ff[latch_ch_ff][3:0]};
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

/* sim/tb_psg_tone_noise_generator.sv */
// Testbench for the tone and noise sound generator: queued stimulus, clocked driver and checker.
`default_nettype none

module tb_psg_tone_noise_generator;

   // register type selected by bit 4 of a latch byte
   localparam logic LATCH_TONE   = 1'b0;
   localparam logic LATCH_VOLUME = 1'b1;
   localparam int   RANDOM_WORDS = 1650;

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
   } psg_word_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_kind   = psg_pkg::KIND_WRITE;
   logic [7:0]        req_data   = 8'h00;
   logic              rsp_stall  = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic signed [16:0] rsp_sample;

   psg_tone_noise_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

   // words waiting to be sent and samples waiting to come back
   psg_word_type      word_q[$];
   logic signed [16:0] sample_q[$];

   int n_writes  = 0;
   int n_ticks   = 0;
   int n_checked = 0;
   int n_errors  = 0;
   int gap_left  = 0;
   int send_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;

   // voice state as the generator should hold it
   logic [9:0]        pitch[3];
   logic [2:0]        noise_mode;
   logic [3:0]        atten[4];
   logic [12:0]       ticks_since[4];
   logic              polarity[3];
   logic [psg_pkg::LFSR_W-1:0] shifter;
   psg_pkg::voice_type sel_voice;
   logic              sel_volume;

   // 2 dB attenuation steps, code 15 silent
   int amplitude[16] = '{8192, 6507, 5169, 4106, 3261, 2591, 2058, 1635,
                         1298, 1031, 819, 651, 517, 411, 326, 0};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_voices();
      for (int i = 0; i < 3; i++) begin
         pitch[i]    = '0;
         polarity[i] = 1'b1;
      end
      for (int i = 0; i < 4; i++) begin
         atten[i]       = psg_pkg::ATT_MUTE;
         ticks_since[i] = '0;
      end
      noise_mode = '0;
      shifter    = psg_pkg::LFSR_SEED;
      sel_voice  = psg_pkg::FIRST_VOICE;
      sel_volume = LATCH_TONE;
   endfunction

   function automatic void apply_write(input logic [7:0] b);
      if (b[7]) begin
         sel_voice  = b[6:5];
         sel_volume = b[4];
         if (sel_volume == LATCH_VOLUME)
            atten[sel_voice] = b[3:0];
         else if (sel_voice != psg_pkg::NOISE_VOICE)
            pitch[sel_voice][3:0] = b[3:0];
         else
            noise_mode = b[2:0];
      end else if (sel_volume == LATCH_TONE && sel_voice != psg_pkg::NOISE_VOICE) begin
         pitch[sel_voice][9:4] = b[5:0];
      end
   endfunction

   // advance the counter of one voice; true when it wraps
   function automatic logic count_wraps(input int v, input int unsigned lim);
      int unsigned nxt;
      nxt = ticks_since[v] + 1;
      if (nxt >= lim) begin
         ticks_since[v] = '0;
         return 1'b1;
      end
      ticks_since[v] = nxt[12:0];
      return 1'b0;
   endfunction

   function automatic logic signed [16:0] mix_sample();
      int          mix;
      int unsigned lim;
      logic        fb;
      mix = 0;
      for (int i = 0; i < 3; i++) begin
         if (atten[i] == psg_pkg::ATT_MUTE || pitch[i] == 10'd0)
            continue;
         if (count_wraps(i, 8 * pitch[i]))
            polarity[i] = ~polarity[i];
         mix += polarity[i] ? amplitude[atten[i]] : -amplitude[atten[i]];
      end
      if (atten[psg_pkg::NOISE_VOICE] != psg_pkg::ATT_MUTE) begin
         if (noise_mode[1:0] == psg_pkg::RATE_TONE)
            lim = 8 * pitch[2];
         else
            lim = 128 << noise_mode[1:0];
         if (count_wraps(psg_pkg::NOISE_VOICE, lim)) begin
            fb      = noise_mode[2] ? (shifter[0] ^ shifter[3]) : shifter[0];
            shifter = {fb, shifter[psg_pkg::LFSR_W-1:1]};
         end
         mix += shifter[0] ? amplitude[atten[psg_pkg::NOISE_VOICE]]
                           : -amplitude[atten[psg_pkg::NOISE_VOICE]];
      end
      return mix[16:0];
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_write(input logic [7:0] b);
      word_q.push_back('{kind: psg_pkg::KIND_WRITE, data: b});
   endtask

   task automatic add_latch(input psg_pkg::voice_type v, input logic kind,
                            input logic [3:0] val);
      add_write({1'b1, v, kind, val});
   endtask

   task automatic add_ticks(input int n);
      repeat (n) word_q.push_back('{kind: psg_pkg::KIND_TICK,
                                    data: 8'($urandom_range(0, 255))});
   endtask

   // upper period bits: mostly small so the tones toggle often
   function automatic logic [7:0] period_high();
      int r;
      r = $urandom_range(0, 99);
      return {1'b0, 1'($urandom_range(0, 1)),
              (r < 60) ? 6'd0 : (r < 85) ? 6'($urandom_range(1, 3)) : 6'($urandom_range(0, 63))};
   endfunction

   task automatic build_directed();
      add_ticks(1);                                  // all muted after reset
      add_latch(2'd0, LATCH_VOLUME, 4'd0);
      add_latch(2'd1, LATCH_VOLUME, 4'd0);
      add_latch(2'd2, LATCH_VOLUME, 4'd14);
      add_latch(psg_pkg::NOISE_VOICE, LATCH_VOLUME, 4'd0);
      add_ticks(1);                                  // zero periods freeze the tones
      add_latch(2'd0, LATCH_TONE, 4'd1);
      add_write(8'h00);                              // shortest tone period
      add_latch(2'd1, LATCH_TONE, 4'hF);
      add_write(8'h7F);                              // longest period, bit 6 ignored
      add_ticks(3);
      add_latch(2'd1, LATCH_TONE, 4'd1);
      add_write(8'h00);                              // period dropped below the count
      add_ticks(1);
      add_latch(2'd0, LATCH_VOLUME, 4'd0);
      add_write(8'h15);                              // data byte after a volume latch
      add_latch(psg_pkg::NOISE_VOICE, LATCH_TONE, 4'hF); // white, borrowed rate, bit 3 dropped
      add_write(8'h2A);                              // data byte after a noise latch
      add_ticks(2);                                  // zero noise period, shift every tick
   endtask

   task automatic build_random();
      int r;
      while (word_q.size() < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            add_latch(psg_pkg::voice_type'($urandom_range(0, 2)), LATCH_TONE,
                      4'($urandom_range(0, 15)));
            if ($urandom_range(0, 9) != 0) add_write(period_high());
         end else if (r < 19) begin
            add_latch(psg_pkg::voice_type'($urandom_range(0, 3)), LATCH_VOLUME,
                      ($urandom_range(0, 6) == 0) ? psg_pkg::ATT_MUTE
                                                  : 4'($urandom_range(0, 14)));
         end else if (r < 22) begin
            add_latch(psg_pkg::NOISE_VOICE, LATCH_TONE, 4'($urandom_range(0, 15)));
         end else if (r < 24) begin
            add_write({1'b0, 7'($urandom_range(0, 127))});
         end else if (r < 25) begin
            add_write(8'($urandom_range(0, 255)));
         end else begin
            add_ticks($urandom_range(1, 24));
         end
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      psg_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // word taken at this edge: update the prediction
         if (req_valid) begin
            if (req_kind == psg_pkg::KIND_TICK) begin
               sample_q.push_back(mix_sample());
               n_ticks++;
            end else begin
               apply_write(req_data);
               n_writes++;
            end
         end
         if (gap_left > 0 || word_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            w = word_q.pop_front();
            req_valid <= 1'b1;
            req_kind  <= w.kind;
            req_data  <= w.data;
            if (send_calm > 0) begin
               send_calm--;
               gap_left = 0;
            end else begin
               gap_left = idle_len();
               if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(20, 100);
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      logic signed [16:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               $error("rsp_sample: no sample expected, actual %0d", rsp_sample);
               n_errors++;
            end else begin
               want = sample_q.pop_front();
               n_checked++;
               if (rsp_sample !== want) begin
                  $error("rsp_sample mismatch: expected %0d, actual %0d", want, rsp_sample);
                  n_errors++;
               end
            end
         end
         // random backpressure with quiet stretches
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_calm > 0) begin
               stall_calm--;
            end else begin
               stall_left = idle_len();
               if ($urandom_range(0, 199) == 0) stall_calm = $urandom_range(30, 150);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_voices();
      build_directed();
      build_random();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (word_q.size() > 0 || req_valid || sample_q.size() > 0)
         @(posedge clock);
      repeat (32) @(posedge clock);
      $display("Sent %0d register bytes and %0d ticks; %0d samples compared.",
               n_writes, n_ticks, n_checked);
      if (n_errors == 0)
         $display("PASS psg_tone_noise_generator");
      else
         $display("FAIL psg_tone_noise_generator");
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("FAIL psg_tone_noise_generator");
      $finish;
   end

endmodule

`default_nettype wire
